// ===== rtl/xbm_hex_body_decoder_top_macros.svh =====
// Assertion macros shared by the X bitmap body decoder RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef XBM_HEX_BODY_DECODER_TOP_MACROS_SVH
`define XBM_HEX_BODY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define XBM_HBD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("xbm_hbd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define XBM_HBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("xbm_hbd: next-cycle check failed");

`endif

// ===== rtl/xbm_hbd_pkg.sv =====
// Package for the X bitmap body decoder: types, register codes, character
// classification and nibble reversal. No dependencies.
package xbm_hbd_pkg;

    localparam logic [16:0] XBM_HBD_MAX_DIM = 17'd4096;

    // Result queue sizing: two results per transfer at most
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // APB register map
    localparam int unsigned AW = 4;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WORD_MODE    = 2'd2;

    // Character classes
    localparam logic [1:0] CLS_BAD    = 2'd0;
    localparam logic [1:0] CLS_DELIM  = 2'd1;
    localparam logic [1:0] CLS_PREFIX = 2'd2;
    localparam logic [1:0] CLS_DIGIT  = 2'd3;

    typedef struct packed {
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic        word_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       error;
        logic       last;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] nibble;
    } cls_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        r.kind   = CLS_BAD;
        r.nibble = 4'd0;
        if (c >= "0" && c <= "9") begin
            r.kind   = CLS_DIGIT;
            r.nibble = 4'(c - 8'h30);
        end else if (c >= "A" && c <= "F") begin
            r.kind   = CLS_DIGIT;
            r.nibble = 4'(c - 8'h37);
        end else if (c >= "a" && c <= "f") begin
            r.kind   = CLS_DIGIT;
            r.nibble = 4'(c - 8'h57);
        end else if (c == "x") begin
            r.kind = CLS_PREFIX;
        end else if (c == 8'h0d || c == 8'h0a || c == 8'h09 || c == " " ||
                     c == "," || c == "}") begin
            r.kind = CLS_DELIM;
        end
        return r;
    endfunction

    function automatic logic [3:0] rev_nibble(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

endpackage

// ===== rtl/xbm_hbd_regs.sv =====
// APB configuration registers for the X bitmap body decoder.
// Depends on xbm_hbd_pkg.
module xbm_hbd_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [xbm_hbd_pkg::AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output xbm_hbd_pkg::cfg_t         cfg
);
    import xbm_hbd_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= 12'd1;
            cfg_reg.image_height <= 12'd1;
            cfg_reg.word_mode    <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[11:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[11:0];
                REG_WORD_MODE:    cfg_reg.word_mode    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_IMAGE_WIDTH:  prdata = {20'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {20'd0, cfg_reg.image_height};
            REG_WORD_MODE:    prdata = {31'd0, cfg_reg.word_mode};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/xbm_hbd_parser.sv =====
// Input register, token parser and row/image tracking for the X bitmap
// body decoder. Depends on xbm_hbd_pkg and the assertion macro header.
`include "xbm_hex_body_decoder_top_macros.svh"

module xbm_hbd_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    input  logic               s_end_of_file,
    input  xbm_hbd_pkg::cfg_t  cfg,
    input  logic               room,
    output xbm_hbd_pkg::push_t push
);
    import xbm_hbd_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        eof_reg;

    logic [15:0] token_reg,  token_next;
    logic [2:0]  dcount_reg, dcount_next;
    logic [11:0] row_reg,    row_next;
    logic [9:0]  bir_reg,    bir_next;
    logic        finished_reg, finished_next;
    logic        failed_reg,   failed_next;

    logic        fire;
    logic        dim_bad;
    cls_t        cls;
    logic [12:0] wsum;
    logic [9:0]  linelen;
    logic [9:0]  bir1, bir2;
    logic [11:0] row_inc;
    logic        end1, end2, last_row;
    logic [15:0] addend;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
            eof_reg  <= s_end_of_file;
        end
    end

    assign cls     = classify(char_reg);
    assign dim_bad = (cfg.image_width == 12'd0) || (cfg.image_height == 12'd0) ||
                     ({5'd0, cfg.image_width} >= XBM_HBD_MAX_DIM) ||
                     ({5'd0, cfg.image_height} >= XBM_HBD_MAX_DIM);
    assign wsum     = {1'b0, cfg.image_width} + 13'd7;
    assign linelen  = wsum[12:3];
    assign bir1     = bir_reg + 10'd1;
    assign bir2     = bir_reg + 10'd2;
    assign end1     = bir1 >= linelen;
    assign end2     = bir2 >= linelen;
    assign row_inc  = row_reg + 12'd1;
    assign last_row = row_inc >= cfg.image_height;
    assign addend   = {12'd0, rev_nibble(cls.nibble)} << {dcount_reg[1:0], 2'b00};

    always_comb begin
        token_next    = token_reg;
        dcount_next   = dcount_reg;
        row_next      = row_reg;
        bir_next      = bir_reg;
        finished_next = finished_reg;
        failed_next   = failed_reg;
        push          = '0;

        if (fire && !finished_reg && !failed_reg) begin
            if (dim_bad || eof_reg || cls.kind == CLS_BAD) begin
                push.v0       = 1'b1;
                push.r0.error = 1'b1;
                failed_next   = 1'b1;
            end else begin
                case (cls.kind)
                    CLS_PREFIX: begin
                        dcount_next = 3'd0;
                    end
                    CLS_DIGIT: begin
                        if (dcount_reg < 3'd4) begin
                            token_next  = token_reg + addend;
                            dcount_next = dcount_reg + 3'd1;
                        end
                    end
                    CLS_DELIM: begin
                        if (dcount_reg != 3'd0) begin
                            token_next          = 16'd0;
                            dcount_next         = 3'd0;
                            push.v0             = 1'b1;
                            push.r0.data_byte   = cfg.word_mode ? token_reg[15:8]
                                                                : token_reg[7:0];
                            if (end1) begin
                                // first byte closes the row
                                bir_next        = 10'd0;
                                row_next        = row_inc;
                                push.r0.last    = last_row;
                                finished_next   = last_row;
                            end else if (cfg.word_mode) begin
                                push.v1           = 1'b1;
                                push.r1.data_byte = token_reg[7:0];
                                if (end2) begin
                                    bir_next      = 10'd0;
                                    row_next      = row_inc;
                                    push.r1.last  = last_row;
                                    finished_next = last_row;
                                end else begin
                                    bir_next      = bir2;
                                end
                            end else begin
                                bir_next        = bir1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg    <= 16'd0;
            dcount_reg   <= 3'd0;
            row_reg      <= 12'd0;
            bir_reg      <= 10'd0;
            finished_reg <= 1'b0;
            failed_reg   <= 1'b0;
        end else begin
            token_reg    <= token_next;
            dcount_reg   <= dcount_next;
            row_reg      <= row_next;
            bir_reg      <= bir_next;
            finished_reg <= finished_next;
            failed_reg   <= failed_next;
        end
    end

    `XBM_HBD_ASSERT_NOW(a_fire_has_room, aclk, aresetn, fire, room)
    `XBM_HBD_ASSERT_NOW(a_second_in_word_mode, aclk, aresetn, push.v1,
        push.v0 && cfg.word_mode && !push.r0.last)
    `XBM_HBD_ASSERT_NEXT(a_error_halts, aclk, aresetn, push.v0 && push.r0.error,
        failed_reg)
    `XBM_HBD_ASSERT_NEXT(a_last_halts, aclk, aresetn,
        (push.v0 && push.r0.last) || (push.v1 && push.r1.last), finished_reg)

endmodule

// ===== rtl/xbm_hbd_out_queue.sv =====
// Four-entry result queue that takes up to two results per cycle and
// hands out one. Depends on xbm_hbd_pkg and the assertion macro header.
`include "xbm_hex_body_decoder_top_macros.svh"

module xbm_hbd_out_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  xbm_hbd_pkg::push_t push,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output xbm_hbd_pkg::res_t  m_res
);
    import xbm_hbd_pkg::*;

    res_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [1:0]     push_n;
    logic           pop;
    logic [QAW-1:0] wr_ptr1;

    assign push_n  = {1'b0, push.v0} + {1'b0, push.v1};
    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign room    = count_reg <= QCW'(QDEPTH - 2);
    assign m_res   = entry_reg[rd_ptr_reg];
    assign wr_ptr1 = wr_ptr_reg + QAW'(1);

    always_ff @(posedge aclk) begin
        if (push.v0) begin
            entry_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            entry_reg[wr_ptr1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + QCW'(push_n) - QCW'(pop);
        end
    end

    `XBM_HBD_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= QCW'(QDEPTH))
    `XBM_HBD_ASSERT_NOW(a_no_overflow, aclk, aresetn, push.v0,
        (count_reg + QCW'(push_n)) <= QCW'(QDEPTH))
    `XBM_HBD_ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !push.v0,
        count_reg == $past(count_reg) - QCW'(1))

endmodule

// ===== rtl/xbm_hex_body_decoder_top.sv =====
// X bitmap hex body decoder: one character per transfer in, image bytes out.
// An item is registered on acceptance and parsed from that register once the
// queue has room. Its zero, one or two results go into a four-entry result
// queue and leave one per cycle while m_ready is high. The first result is
// presented once its character has been parsed and written into the queue.
// A character can be accepted every cycle while the queue holds at most two
// results. Back-to-back input therefore stalls only when the output is held
// off, or when X10 words give bytes faster than the output drains one per cycle.
// Width, height and word mode are set over APB at 0x0, 0x4 and 0x8.
// Depends on xbm_hbd_pkg, xbm_hbd_regs, xbm_hbd_parser and xbm_hbd_out_queue.
module xbm_hex_body_decoder_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xbm_hbd_pkg::AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_char_code,
    input  logic                       s_end_of_file,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_data_byte,
    output logic                       m_error,
    output logic                       m_last
);
    import xbm_hbd_pkg::*;

    cfg_t  cfg;
    push_t push;
    res_t  m_res;
    logic  room;

    xbm_hbd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    xbm_hbd_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_file (s_end_of_file),
        .cfg           (cfg),
        .room          (room),
        .push          (push)
    );

    xbm_hbd_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_data_byte = m_res.data_byte;
    assign m_error     = m_res.error;
    assign m_last      = m_res.last;

endmodule
